/* design/oas_pkg.sv */
package oas_pkg;

    localparam int FRAC_BITS = 12;

    localparam int HEAD_W  = 15;
    localparam int RATE_W  = 16;
    localparam int ACC_W   = 16;
    localparam int TOL_W   = 14;
    localparam int RT_W    = 16;
    localparam int MTR_W   = 15;
    localparam int MTA_W   = 15;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;
    localparam int ERR_W   = HEAD_W + 2;
    localparam int MAG_W   = 14;
    localparam int PROD_W  = MTR_W + MAG_W;
    localparam int DIFF_W  = RATE_W + 2;
    localparam int DEN_W   = RT_W + 1;
    localparam int NUM_W   = RATE_W + FRAC_BITS + 2;
    localparam int QB_W    = MTA_W;

    localparam logic signed [ERR_W-1:0] PI_FX     = ERR_W'(12868);
    localparam logic signed [ERR_W-1:0] TWO_PI_FX = ERR_W'(25736);

    localparam logic [RT_W-1:0] REACH_RESET = RT_W'(((1 << FRAC_BITS) + 5) / 10);

    typedef enum logic [IDX_W-1:0] {
        IDX_ALIGN_TOL  = 3'd0,
        IDX_SLOW_RAD   = 3'd1,
        IDX_REACH_TIME = 3'd2,
        IDX_MAX_RATE   = 3'd3,
        IDX_MAX_ACCEL  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [TOL_W-1:0] align_tolerance;
        logic [TOL_W-1:0] slow_radius;
        logic [RT_W-1:0]  reach_time;
        logic [MTR_W-1:0] max_turn_rate;
        logic [MTA_W-1:0] max_turn_accel;
    } cfg_t;

    typedef struct packed {
        logic                     neg;
        logic [MAG_W-1:0]         mag;
        logic signed [RATE_W-1:0] rate;
    } err_t;

    typedef struct packed {
        logic                     aligned;
        logic                     neg;
        logic                     scale;
        logic signed [RATE_W-1:0] rate;
    } side_a_t;

    typedef struct packed {
        logic              aligned;
        logic              neg;
        logic [RATE_W-1:0] amag;
    } diff_t;

    typedef struct packed {
        logic aligned;
        logic neg;
        logic ovf;
    } side_b_t;

endpackage

/* design/oas_stream_if.sv */
interface oas_req_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [oas_pkg::HEAD_W-1:0]    target_heading;
    logic signed [oas_pkg::HEAD_W-1:0]    current_heading;
    logic signed [oas_pkg::RATE_W-1:0]    current_turn_rate;

    modport source (output valid, target_heading, current_heading, current_turn_rate,
                    input ready);
    modport sink   (input valid, target_heading, current_heading, current_turn_rate,
                    output ready);
endinterface

interface oas_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [oas_pkg::ACC_W-1:0]    turn_accel;
    logic                                aligned;

    modport source (output valid, turn_accel, aligned, input ready);
    modport sink   (input valid, turn_accel, aligned, output ready);
endinterface

/* design/oas_err.sv */
module oas_err (
    input  logic                              clk,
    input  logic                              rst_n,
    input  oas_pkg::cfg_t                     cfg,
    input  logic                              in_vld,
    output logic                              in_rdy,
    input  logic signed [oas_pkg::HEAD_W-1:0] tgt,
    input  logic signed [oas_pkg::HEAD_W-1:0] cur,
    input  logic signed [oas_pkg::RATE_W-1:0] rate,
    output logic                              out_vld,
    input  logic                              out_rdy,
    output oas_pkg::side_a_t                  out_side,
    output logic [oas_pkg::PROD_W-1:0]        out_prod
);

    logic                               s1_vld_reg;
    oas_pkg::err_t                      s1_reg;
    oas_pkg::err_t                      s1_next;
    logic                               s1_rdy;
    logic                               s2_vld_reg;
    oas_pkg::side_a_t                   s2_side_reg;
    oas_pkg::side_a_t                   s2_side_next;
    logic [oas_pkg::PROD_W-1:0]         s2_prod_reg;
    logic [oas_pkg::PROD_W-1:0]         s2_prod_next;
    logic                               s2_rdy;
    logic signed [oas_pkg::ERR_W-1:0]   raw;
    logic signed [oas_pkg::ERR_W-1:0]   wrapped;
    logic signed [oas_pkg::ERR_W-1:0]   absval;

    assign s2_rdy = !s2_vld_reg || out_rdy;
    assign s1_rdy = !s1_vld_reg || s2_rdy;
    assign in_rdy = s1_rdy;

    // heading error, one wrap step
    always_comb
    begin
        raw = oas_pkg::ERR_W'(tgt) - oas_pkg::ERR_W'(cur);
        if (raw >= oas_pkg::PI_FX)
        begin
            wrapped = raw - oas_pkg::TWO_PI_FX;
        end
        else if (raw < -oas_pkg::PI_FX)
        begin
            wrapped = raw + oas_pkg::TWO_PI_FX;
        end
        else
        begin
            wrapped = raw;
        end
        absval       = wrapped[oas_pkg::ERR_W-1] ? -wrapped : wrapped;
        s1_next.neg  = wrapped[oas_pkg::ERR_W-1];
        s1_next.mag  = absval[oas_pkg::MAG_W-1:0];
        s1_next.rate = rate;
    end

    always_comb
    begin
        s2_side_next.aligned = (s1_reg.mag <= cfg.align_tolerance);
        s2_side_next.neg     = s1_reg.neg;
        s2_side_next.scale   = (s1_reg.mag <= cfg.slow_radius) && (cfg.slow_radius != '0);
        s2_side_next.rate    = s1_reg.rate;
        s2_prod_next         = oas_pkg::PROD_W'(cfg.max_turn_rate)
                             * oas_pkg::PROD_W'(s1_reg.mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            if (s1_rdy)
            begin
                s1_vld_reg <= in_vld;
            end
            if (s2_rdy)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_rdy && in_vld)
        begin
            s1_reg <= s1_next;
        end
        if (s2_rdy && s1_vld_reg)
        begin
            s2_side_reg <= s2_side_next;
            s2_prod_reg <= s2_prod_next;
        end
    end

    assign out_vld  = s2_vld_reg;
    assign out_side = s2_side_reg;
    assign out_prod = s2_prod_reg;

endmodule

/* design/oas_udiv.sv */
module oas_udiv #(
    parameter int QW = 15,
    parameter int DW = 14,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_vld,
    output logic          in_rdy,
    input  logic [DW-1:0] in_rem,
    input  logic [QW-1:0] in_low,
    input  logic [DW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_vld,
    input  logic          out_rdy,
    output logic [QW-1:0] out_quo,
    output logic [SW-1:0] out_side
);

    logic          vld_reg  [QW];
    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] low_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [SW-1:0] side_reg [QW];
    logic          rdy      [QW+1];

    assign rdy[QW]  = out_rdy;
    assign in_rdy   = rdy[0];
    assign out_vld  = vld_reg[QW-1];
    assign out_quo  = quo_reg[QW-1];
    assign out_side = side_reg[QW-1];

    // one quotient bit per stage, restoring
    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic          src_vld;
        logic [DW-1:0] src_rem;
        logic [QW-1:0] src_low;
        logic [QW-1:0] src_quo;
        logic [DW-1:0] src_den;
        logic [SW-1:0] src_side;
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] quo_next;

        if (i == 0)
        begin : g_first
            assign src_vld  = in_vld;
            assign src_rem  = in_rem;
            assign src_low  = in_low;
            assign src_quo  = '0;
            assign src_den  = in_den;
            assign src_side = in_side;
        end
        else
        begin : g_rest
            assign src_vld  = vld_reg[i-1];
            assign src_rem  = rem_reg[i-1];
            assign src_low  = low_reg[i-1];
            assign src_quo  = quo_reg[i-1];
            assign src_den  = den_reg[i-1];
            assign src_side = side_reg[i-1];
        end

        assign rdy[i] = !vld_reg[i] || rdy[i+1];

        always_comb
        begin
            trial    = {src_rem, src_low[QW-1]};
            ge       = (trial >= {1'b0, src_den});
            rem_next = ge ? DW'(trial - {1'b0, src_den}) : DW'(trial);
            quo_next = {src_quo[QW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (rdy[i])
            begin
                vld_reg[i] <= src_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[i] && src_vld)
            begin
                rem_reg[i]  <= rem_next;
                low_reg[i]  <= {src_low[QW-2:0], 1'b0};
                quo_reg[i]  <= quo_next;
                den_reg[i]  <= src_den;
                side_reg[i] <= src_side;
            end
        end
    end

endmodule

/* design/oas_prep.sv */
module oas_prep (
    input  logic                             clk,
    input  logic                             rst_n,
    input  oas_pkg::cfg_t                    cfg,
    input  logic                             in_vld,
    output logic                             in_rdy,
    input  logic [oas_pkg::MTR_W-1:0]        in_quo,
    input  oas_pkg::side_a_t                 in_side,
    output logic                             out_vld,
    input  logic                             out_rdy,
    output logic [oas_pkg::DEN_W-1:0]        out_rem,
    output logic [oas_pkg::QB_W-1:0]         out_low,
    output logic [oas_pkg::DEN_W-1:0]        out_den,
    output oas_pkg::side_b_t                 out_side
);

    logic                               s1_vld_reg;
    oas_pkg::diff_t                     s1_reg;
    oas_pkg::diff_t                     s1_next;
    logic                               s1_rdy;
    logic                               s2_vld_reg;
    logic [oas_pkg::DEN_W-1:0]          rem_reg;
    logic [oas_pkg::DEN_W-1:0]          rem_next;
    logic [oas_pkg::QB_W-1:0]           low_reg;
    logic [oas_pkg::QB_W-1:0]           low_next;
    logic [oas_pkg::DEN_W-1:0]          den_reg;
    logic [oas_pkg::DEN_W-1:0]          den_next;
    oas_pkg::side_b_t                   side_reg;
    oas_pkg::side_b_t                   side_next;
    logic                               s2_rdy;
    logic [oas_pkg::MTR_W-1:0]          dmag;
    logic signed [oas_pkg::DIFF_W-1:0]  desired;
    logic signed [oas_pkg::DIFF_W-1:0]  diff;
    logic signed [oas_pkg::DIFF_W-1:0]  adiff;
    logic [oas_pkg::RT_W-1:0]           divisor;
    logic [oas_pkg::NUM_W-1:0]          num;

    assign s2_rdy = !s2_vld_reg || out_rdy;
    assign s1_rdy = !s1_vld_reg || s2_rdy;
    assign in_rdy = s1_rdy;

    always_comb
    begin
        dmag    = in_side.scale ? in_quo : cfg.max_turn_rate;
        desired = in_side.neg ? -oas_pkg::DIFF_W'(dmag) : oas_pkg::DIFF_W'(dmag);
        diff    = desired - oas_pkg::DIFF_W'(in_side.rate);
        adiff   = diff[oas_pkg::DIFF_W-1] ? -diff : diff;
        s1_next.aligned = in_side.aligned;
        s1_next.neg     = diff[oas_pkg::DIFF_W-1];
        s1_next.amag    = adiff[oas_pkg::RATE_W-1:0];
    end

    // rounded quotient: (2*num + div) / (2*div), saturate when it needs more than QB_W bits
    always_comb
    begin
        divisor = (cfg.reach_time == '0) ? oas_pkg::RT_W'(1) : cfg.reach_time;
        den_next = {divisor, 1'b0};
        num = {s1_reg.amag, {(oas_pkg::FRAC_BITS + 1){1'b0}}}
            + oas_pkg::NUM_W'(divisor);
        rem_next = oas_pkg::DEN_W'(num[oas_pkg::NUM_W-1:oas_pkg::QB_W]);
        low_next = num[oas_pkg::QB_W-1:0];
        side_next.aligned = s1_reg.aligned;
        side_next.neg     = s1_reg.neg;
        side_next.ovf     = (rem_next >= den_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            if (s1_rdy)
            begin
                s1_vld_reg <= in_vld;
            end
            if (s2_rdy)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_rdy && in_vld)
        begin
            s1_reg <= s1_next;
        end
        if (s2_rdy && s1_vld_reg)
        begin
            rem_reg  <= rem_next;
            low_reg  <= low_next;
            den_reg  <= den_next;
            side_reg <= side_next;
        end
    end

    assign out_vld  = s2_vld_reg;
    assign out_rem  = rem_reg;
    assign out_low  = low_reg;
    assign out_den  = den_reg;
    assign out_side = side_reg;

endmodule

/* design/oas_clamp.sv */
module oas_clamp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  oas_pkg::cfg_t             cfg,
    input  logic                      in_vld,
    output logic                      in_rdy,
    input  logic [oas_pkg::QB_W-1:0]  in_quo,
    input  oas_pkg::side_b_t          in_side,
    oas_rsp_if.source                 rsp
);

    logic                               vld_reg;
    logic signed [oas_pkg::ACC_W-1:0]   accel_reg;
    logic signed [oas_pkg::ACC_W-1:0]   accel_next;
    logic                               aligned_reg;
    logic [oas_pkg::MTA_W-1:0]          qmag;

    assign in_rdy = !vld_reg || rsp.ready;

    always_comb
    begin
        qmag = (in_side.ovf || (in_quo > cfg.max_turn_accel)) ? cfg.max_turn_accel : in_quo;
        if (in_side.aligned)
        begin
            accel_next = '0;
        end
        else if (in_side.neg)
        begin
            accel_next = -oas_pkg::ACC_W'(qmag);
        end
        else
        begin
            accel_next = oas_pkg::ACC_W'(qmag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_rdy)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_rdy && in_vld)
        begin
            accel_reg   <= accel_next;
            aligned_reg <= in_side.aligned;
        end
    end

    assign rsp.valid      = vld_reg;
    assign rsp.turn_accel = accel_reg;
    assign rsp.aligned    = aligned_reg;

endmodule

/* design/orientation_align_steering_core.sv */
// Align-to-heading steering. Each request carries target heading, current heading and
// current turn rate (signed Q12); the response gives the turn acceleration, clamped to
// max_turn_accel, and an aligned flag (acceleration zero). Fully pipelined: one request
// per cycle when the response side does not stall (2 error/multiply
// stages, 15 stages for the slow-down scaling divide, 2 rate stages, 15 stages for the
// divide by reach_time, 1 output register). Write configuration only while idle.
module orientation_align_steering_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [oas_pkg::IDX_W-1:0]     cfg_index,
    input  logic [oas_pkg::CFG_W-1:0]     cfg_data,
    oas_req_if.sink                       req,
    oas_rsp_if.source                     rsp
);

    oas_pkg::cfg_t                   cfg_reg;
    logic                            a_vld;
    logic                            a_rdy;
    oas_pkg::side_a_t                a_side;
    logic [oas_pkg::PROD_W-1:0]      a_prod;
    logic                            b_vld;
    logic                            b_rdy;
    logic [oas_pkg::MTR_W-1:0]       b_quo;
    logic [$bits(oas_pkg::side_a_t)-1:0] b_side;
    logic                            c_vld;
    logic                            c_rdy;
    logic [oas_pkg::DEN_W-1:0]       c_rem;
    logic [oas_pkg::QB_W-1:0]        c_low;
    logic [oas_pkg::DEN_W-1:0]       c_den;
    oas_pkg::side_b_t                c_side;
    logic                            d_vld;
    logic                            d_rdy;
    logic [oas_pkg::QB_W-1:0]        d_quo;
    logic [$bits(oas_pkg::side_b_t)-1:0] d_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.align_tolerance <= '0;
            cfg_reg.slow_radius     <= '0;
            cfg_reg.reach_time      <= oas_pkg::REACH_RESET;
            cfg_reg.max_turn_rate   <= '0;
            cfg_reg.max_turn_accel  <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (oas_pkg::cfg_idx_t'(cfg_index))
                oas_pkg::IDX_ALIGN_TOL:
                    cfg_reg.align_tolerance <= cfg_data[oas_pkg::TOL_W-1:0];
                oas_pkg::IDX_SLOW_RAD:
                    cfg_reg.slow_radius <= cfg_data[oas_pkg::TOL_W-1:0];
                oas_pkg::IDX_REACH_TIME:
                    cfg_reg.reach_time <= cfg_data[oas_pkg::RT_W-1:0];
                oas_pkg::IDX_MAX_RATE:
                    cfg_reg.max_turn_rate <= cfg_data[oas_pkg::MTR_W-1:0];
                oas_pkg::IDX_MAX_ACCEL:
                    cfg_reg.max_turn_accel <= cfg_data[oas_pkg::MTA_W-1:0];
                default:
                    ;
            endcase
        end
    end

    oas_err u_err (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_vld   (req.valid),
        .in_rdy   (req.ready),
        .tgt      (req.target_heading),
        .cur      (req.current_heading),
        .rate     (req.current_turn_rate),
        .out_vld  (a_vld),
        .out_rdy  (a_rdy),
        .out_side (a_side),
        .out_prod (a_prod)
    );

    oas_udiv #(
        .QW (oas_pkg::MTR_W),
        .DW (oas_pkg::MAG_W),
        .SW ($bits(oas_pkg::side_a_t))
    ) u_scale_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (a_vld),
        .in_rdy   (a_rdy),
        .in_rem   (a_prod[oas_pkg::PROD_W-1:oas_pkg::MTR_W]),
        .in_low   (a_prod[oas_pkg::MTR_W-1:0]),
        .in_den   (cfg_reg.slow_radius),
        .in_side  (a_side),
        .out_vld  (b_vld),
        .out_rdy  (b_rdy),
        .out_quo  (b_quo),
        .out_side (b_side)
    );

    oas_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_vld   (b_vld),
        .in_rdy   (b_rdy),
        .in_quo   (b_quo),
        .in_side  (oas_pkg::side_a_t'(b_side)),
        .out_vld  (c_vld),
        .out_rdy  (c_rdy),
        .out_rem  (c_rem),
        .out_low  (c_low),
        .out_den  (c_den),
        .out_side (c_side)
    );

    oas_udiv #(
        .QW (oas_pkg::QB_W),
        .DW (oas_pkg::DEN_W),
        .SW ($bits(oas_pkg::side_b_t))
    ) u_accel_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (c_vld),
        .in_rdy   (c_rdy),
        .in_rem   (c_rem),
        .in_low   (c_low),
        .in_den   (c_den),
        .in_side  (c_side),
        .out_vld  (d_vld),
        .out_rdy  (d_rdy),
        .out_quo  (d_quo),
        .out_side (d_side)
    );

    oas_clamp u_clamp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .in_vld  (d_vld),
        .in_rdy  (d_rdy),
        .in_quo  (d_quo),
        .in_side (oas_pkg::side_b_t'(d_side)),
        .rsp     (rsp)
    );

endmodule

/* design/oas_checker.sv */
module oas_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_ready,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic signed [oas_pkg::ACC_W-1:0]  turn_accel,
    input logic                              aligned
);

    a_aligned_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && aligned |-> turn_accel == '0)
        else $error("aligned response with nonzero acceleration");

    a_no_min_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> turn_accel != {1'b1, {(oas_pkg::ACC_W-1){1'b0}}})
        else $error("acceleration outside clamp range");

    a_ready_flows: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_ready |-> req_ready)
        else $error("request stalled while response side is ready");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(turn_accel) && $stable(aligned))
        else $error("stalled response changed");

endmodule

bind orientation_align_steering_core oas_checker u_oas_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .turn_accel (rsp.turn_accel),
    .aligned    (rsp.aligned)
);

/* sim/tb_orientation_align_steering_core.sv */
module tb_orientation_align_steering_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 35;

    typedef struct {
        logic signed [oas_pkg::ACC_W-1:0] turn_accel;
        logic                             aligned;
    } steer_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [oas_pkg::IDX_W-1:0] cfg_index;
    logic [oas_pkg::CFG_W-1:0] cfg_data;

    oas_req_if req ();
    oas_rsp_if rsp ();

    orientation_align_steering_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    logic [oas_pkg::TOL_W-1:0] m_tol;
    logic [oas_pkg::TOL_W-1:0] m_slow;
    logic [oas_pkg::RT_W-1:0]  m_reach;
    logic [oas_pkg::MTR_W-1:0] m_max_rate;
    logic [oas_pkg::MTA_W-1:0] m_max_accel;

    steer_t pending_steer[$];
    int errors;
    int burst_left;
    int stall_mode;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic steer_t predict_steer(logic signed [oas_pkg::HEAD_W-1:0] tgt,
                                             logic signed [oas_pkg::HEAD_W-1:0] cur,
                                             logic signed [oas_pkg::RATE_W-1:0] rate);
        longint err;
        longint mag;
        longint dmag;
        longint desired;
        longint diff;
        longint num;
        longint div;
        longint q;
        steer_t s;
        err = longint'(tgt) - longint'(cur);
        if (err >= 12868)
            err -= 25736;
        else if (err < -12868)
            err += 25736;
        mag = err < 0 ? -err : err;
        if (mag <= m_tol)
        begin
            s.turn_accel = '0;
            s.aligned = 1'b1;
            return s;
        end
        dmag = m_max_rate;
        if (mag <= m_slow && m_slow != 0)
            dmag = (longint'(m_max_rate) * mag) / m_slow;
        desired = err < 0 ? -dmag : dmag;
        diff = desired - longint'(rate);
        num = (diff < 0 ? -diff : diff) << oas_pkg::FRAC_BITS;
        div = m_reach == 0 ? 1 : m_reach;
        q = (2 * num + div) / (2 * div);
        if (q > m_max_accel)
            q = m_max_accel;
        s.turn_accel = oas_pkg::ACC_W'(diff < 0 ? -q : q);
        s.aligned = 1'b0;
        return s;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    task automatic write_reg(oas_pkg::cfg_idx_t idx, int value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= oas_pkg::CFG_W'(value);
        case (idx)
            oas_pkg::IDX_ALIGN_TOL:  m_tol = oas_pkg::TOL_W'(value);
            oas_pkg::IDX_SLOW_RAD:   m_slow = oas_pkg::TOL_W'(value);
            oas_pkg::IDX_REACH_TIME: m_reach = oas_pkg::RT_W'(value);
            oas_pkg::IDX_MAX_RATE:   m_max_rate = oas_pkg::MTR_W'(value);
            oas_pkg::IDX_MAX_ACCEL:  m_max_accel = oas_pkg::MTA_W'(value);
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(int tol, int slow, int reach, int mrate, int maccel);
        write_reg(oas_pkg::IDX_ALIGN_TOL, tol);
        write_reg(oas_pkg::IDX_SLOW_RAD, slow);
        write_reg(oas_pkg::IDX_REACH_TIME, reach);
        write_reg(oas_pkg::IDX_MAX_RATE, mrate);
        write_reg(oas_pkg::IDX_MAX_ACCEL, maccel);
    endtask

    task automatic drain();
        while (pending_steer.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // bursts with random gaps; valid stays high across back-to-back requests
    task automatic send_request(int tgt, int cur, int rate);
        if (burst_left == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
        req.valid <= 1'b1;
        req.target_heading <= oas_pkg::HEAD_W'(tgt);
        req.current_heading <= oas_pkg::HEAD_W'(cur);
        req.current_turn_rate <= oas_pkg::RATE_W'(rate);
        do
            @(posedge clk);
        while (!req.ready);
        pending_steer.push_back(predict_steer(oas_pkg::HEAD_W'(tgt), oas_pkg::HEAD_W'(cur),
                                              oas_pkg::RATE_W'(rate)));
        burst_left--;
        if (burst_left == 0)
            req.valid <= 1'b0;
    endtask

    task automatic end_requests();
        req.valid <= 1'b0;
        burst_left = 0;
    endtask

    function automatic int rand_head();
        return $urandom_range(0, 1) ? int'($urandom_range(0, 32767)) - 16384
                                    : int'($urandom_range(0, 25736)) - 12868;
    endfunction

    function automatic int rand_rate();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    task automatic test_reset_config();
        send_request(1000, 0, 0);
        send_request(0, 0, 0);
        send_request(-5000, 200, 32767);
        end_requests();
        drain();
    endtask

    task automatic test_directed();
        set_config(100, 4000, 410, 20000, 30000);
        send_request(12868, -12868, 0);
        send_request(12868, 0, 0);
        send_request(-12868, 0, 0);
        send_request(16383, -16384, -32768);
        send_request(-16384, 16383, 32767);
        send_request(100, 0, 5);
        send_request(101, 0, 5);
        send_request(-101, 0, -5);
        send_request(2000, 0, 0);
        send_request(4000, 0, 0);
        send_request(4001, 0, -32768);
        send_request(-3000, 0, 32767);
        end_requests();
        drain();
        set_config(0, 0, 0, 32767, 32767);
        send_request(1, 0, 0);
        send_request(-1, 0, 32767);
        send_request(0, 0, 0);
        send_request(12000, -500, -32768);
        end_requests();
        drain();
        set_config(12868, 12868, 65535, 0, 0);
        send_request(12868, -12868, 1);
        send_request(16383, -16384, -7);
        end_requests();
        drain();
        set_config(16383, 16383, 1, 32767, 0);
        send_request(5, -5, 100);
        end_requests();
        drain();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: set_config(0, 0, 1, 32767, 32767);
                1: set_config(12868, 12868, 65535, 32767, 32767);
                2: set_config(16383, 0, 0, 0, 0);
                default: set_config($urandom_range(0, 2000), $urandom_range(0, 12868),
                                    $urandom_range(0, 65535) >> $urandom_range(0, 12),
                                    $urandom_range(0, 32767), $urandom_range(0, 32767));
            endcase
            stall_mode = phase % 4;
            for (int n = 0; n < 125; n++)
                send_request(rand_head(), rand_head(), rand_rate());
            end_requests();
            drain();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            case (stall_mode)
                0: rsp.ready <= 1'b1;
                1: rsp.ready <= ($urandom_range(0, 3) != 0);
                2: rsp.ready <= ($urandom_range(0, 1) != 0);
                default: rsp.ready <= ($urandom_range(0, 7) == 0);
            endcase
    end

    always @(posedge clk)
    begin
        steer_t exp_s;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_steer.size() == 0)
            begin
                report_mismatch("unexpected response", 1, 0);
            end
            else
            begin
                exp_s = pending_steer.pop_front();
                if (rsp.turn_accel !== exp_s.turn_accel)
                    report_mismatch("turn_accel", rsp.turn_accel, exp_s.turn_accel);
                if (rsp.aligned !== exp_s.aligned)
                    report_mismatch("aligned", rsp.aligned, exp_s.aligned);
            end
        end
    end

    initial
    begin
        errors = 0;
        burst_left = 0;
        stall_mode = 1;
        m_tol = '0;
        m_slow = '0;
        m_reach = oas_pkg::REACH_RESET;
        m_max_rate = '0;
        m_max_accel = '0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req.valid = 1'b0;
        req.target_heading = '0;
        req.current_heading = '0;
        req.current_turn_rate = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_config();
        test_directed();
        test_random();
        if (errors == 0 && pending_steer.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

endmodule
